@@ design/sha256_pkg.sv @@
// Shared types, constants and round functions for the SHA-256 block hash unit.
package sha256_pkg;

    localparam int unsigned WordW   = 32;
    localparam int unsigned NumVars = 8;
    localparam int unsigned RingLen = 16;
    localparam int unsigned NumRnd  = 64;

    typedef logic [WordW-1:0] t_word;

    // Controller states
    typedef enum logic [1:0] {
        S_LOAD,
        S_ROUND,
        S_ADD,
        S_EMIT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic       load;      // shift a message word into the ring
        logic       init_vars; // copy hash state into working variables
        logic       round;     // run one compression round
        logic [5:0] rnd;       // round number
        logic       add;       // fold working variables into hash state
        logic       restore;   // return hash state to the initial values
        logic [2:0] emit_idx;  // digest word on the output
    } t_cmd;

    localparam t_word InitH [NumVars] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word RoundK [NumRnd] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (WordW - n));
    endfunction

    function automatic t_word big_sig0(input t_word x);
        big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_sig1(input t_word x);
        big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word small_sig0(input t_word x);
        small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_sig1(input t_word x);
        small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

@@ design/sha256_ctrl.sv @@
// Controller state machine: word loading, round sequencing and digest output.
module sha256_ctrl
    import sha256_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_final_word,
    input  logic i_out_ready,
    output logic o_in_ready,
    output logic o_out_valid,
    output logic o_digest_last,
    output t_cmd o_cmd
);

    t_state     r_state, n_state;
    logic [3:0] r_cnt;
    logic [5:0] r_rnd;
    logic [2:0] r_idx;
    logic       r_final;
    logic       in_fire;
    logic       out_fire;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_fire = o_out_valid && i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (in_fire && r_cnt == 4'd15) n_state = S_ROUND;
            end
            S_ROUND: begin
                if (r_rnd == 6'd63) n_state = S_ADD;
            end
            S_ADD: begin
                n_state = r_final ? S_EMIT : S_LOAD;
            end
            S_EMIT: begin
                if (out_fire && r_idx == 3'd7) n_state = S_LOAD;
            end
            default: n_state = S_LOAD;
        endcase
    end

    // Outputs and commands
    always_comb begin
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        o_cmd         = '0;
        o_cmd.rnd     = r_rnd;
        o_cmd.emit_idx = r_idx;
        case (r_state)
            S_LOAD: begin
                o_in_ready     = 1'b1;
                o_cmd.load     = in_fire;
                o_cmd.init_vars = in_fire && r_cnt == 4'd15;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
            end
            S_EMIT: begin
                // take words of the next block, but hold its last word back
                o_in_ready    = r_cnt != 4'd15;
                o_out_valid   = 1'b1;
                o_cmd.load    = in_fire;
                o_cmd.restore = out_fire && r_idx == 3'd7;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    assign o_digest_last = r_idx == 3'd7;

    // State, counters and final mark
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_rnd   <= '0;
            r_idx   <= '0;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_fire) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) r_final <= i_final_word;
            end
            if (r_state == S_ROUND) r_rnd <= r_rnd + 6'd1;
            if (out_fire) r_idx <= r_idx + 3'd1;
        end
    end

endmodule

@@ design/sha256_dpath.sv @@
// Datapath: schedule shift line, working variables, round logic and hash state.
module sha256_dpath
    import sha256_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cmd  i_cmd,
    input  t_word i_message_word,
    output t_word o_digest_word
);

    t_word r_ring [RingLen];
    t_word r_var  [NumVars];
    t_word r_hash [NumVars];
    t_word w_new, w_t, t1, t2, ch, maj;

    // Schedule word and round terms; ring holds W[t-16..t-1] oldest first
    always_comb begin
        w_new = small_sig1(r_ring[14]) + r_ring[9] + small_sig0(r_ring[1]) + r_ring[0];
        w_t   = (i_cmd.rnd[5:4] == 2'd0) ? r_ring[0] : w_new;
        ch    = (r_var[4] & r_var[5]) ^ (~r_var[4] & r_var[6]);
        maj   = (r_var[0] & r_var[1]) ^ (r_var[0] & r_var[2]) ^ (r_var[1] & r_var[2]);
        t1    = r_var[7] + big_sig1(r_var[4]) + ch + RoundK[i_cmd.rnd] + w_t;
        t2    = big_sig0(r_var[0]) + maj;
    end

    assign o_digest_word = r_hash[i_cmd.emit_idx];

    // Advance the schedule line
    always_ff @(posedge i_clk) begin
        if (i_cmd.load || i_cmd.round) begin
            for (int i = 0; i < RingLen - 1; i++) r_ring[i] <= r_ring[i+1];
            r_ring[RingLen-1] <= i_cmd.load ? i_message_word : w_t;
        end
    end

    // Working variables and hash state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NumVars; i++) begin
                r_var[i]  <= '0;
                r_hash[i] <= InitH[i];
            end
        end else begin
            if (i_cmd.init_vars) begin
                for (int i = 0; i < NumVars; i++) r_var[i] <= r_hash[i];
            end else if (i_cmd.round) begin
                r_var[7] <= r_var[6];
                r_var[6] <= r_var[5];
                r_var[5] <= r_var[4];
                r_var[4] <= r_var[3] + t1;
                r_var[3] <= r_var[2];
                r_var[2] <= r_var[1];
                r_var[1] <= r_var[0];
                r_var[0] <= t1 + t2;
            end
            if (i_cmd.add) begin
                for (int i = 0; i < NumVars; i++) r_hash[i] <= r_hash[i] + r_var[i];
            end else if (i_cmd.restore) begin
                for (int i = 0; i < NumVars; i++) r_hash[i] <= InitH[i];
            end
        end
    end

endmodule

@@ design/sha256_block_hash_unit.sv @@
// SHA-256 block hash unit: one message word per beat in, eight digest words out.
// The sixteenth word of a block starts 64 rounds at one round per cycle, followed by
// the hash add. After a final block the first digest word is offered once the add
// is done, then one word per cycle while the digest side takes them.
// Synchronous active-low reset loads the initial hash values and clears control.
module sha256_block_hash_unit
    import sha256_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_message_word,
    input  logic        i_final_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_digest_index,
    output logic        o_digest_last
);

    t_cmd cmd;

    sha256_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_final_word  (i_final_word),
        .i_out_ready   (i_out_ready),
        .o_in_ready    (o_in_ready),
        .o_out_valid   (o_out_valid),
        .o_digest_last (o_digest_last),
        .o_cmd         (cmd)
    );

    sha256_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_message_word (i_message_word),
        .o_digest_word  (o_digest_word)
    );

    assign o_digest_index = cmd.emit_idx;

    // No word is taken while rounds run
    a_no_load_in_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.round |-> !o_in_ready)
        else $error("input taken during compression rounds");

    // Rounds and digest output never overlap
    a_round_not_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.round |-> !o_out_valid)
        else $error("digest shown during compression rounds");

    // The digest index steps by one after each taken beat
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |=> (o_digest_index == $past(o_digest_index) + 3'd1))
        else $error("digest index did not advance");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the SHA-256 block hash unit with a word-level digest predictor.
`timescale 1ns / 100ps

module tb;

    localparam int DirRows    = 24;
    localparam int RandItems  = 196;
    localparam int StallLimit = 2000;
    localparam int DrainWait  = 100;

    // One directed row: message word, final mark, digest typed in below
    typedef struct packed {
        logic [31:0] word;
        logic        fin;
        logic        known;
    } t_row;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_beat;

    // Digest of the three-byte message "abc"
    localparam logic [31:0] AbcDigest [8] = '{
        32'hba7816bf, 32'h8f01cfea, 32'h414140de, 32'h5dae2223,
        32'hb00361a3, 32'h96177a9c, 32'hb410ff61, 32'hf20015ad
    };

    localparam logic [31:0] StartH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundConst [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Directed rows: padded "abc" block with a stray final mark mid-block,
    // then field extremes that open the next block (random words complete it)
    localparam t_row StimRows [DirRows] = '{
        {32'h61626380, 1'b0, 1'b0}, {32'h00000000, 1'b0, 1'b0},
        {32'h00000000, 1'b0, 1'b0}, {32'h00000000, 1'b0, 1'b0},
        {32'h00000000, 1'b0, 1'b0}, {32'h00000000, 1'b1, 1'b0},
        {32'h00000000, 1'b0, 1'b0}, {32'h00000000, 1'b0, 1'b0},
        {32'h00000000, 1'b0, 1'b0}, {32'h00000000, 1'b0, 1'b0},
        {32'h00000000, 1'b0, 1'b0}, {32'h00000000, 1'b0, 1'b0},
        {32'h00000000, 1'b0, 1'b0}, {32'h00000000, 1'b0, 1'b0},
        {32'h00000000, 1'b0, 1'b0}, {32'h00000018, 1'b1, 1'b1},
        {32'h00000000, 1'b0, 1'b0}, {32'hffffffff, 1'b1, 1'b0},
        {32'h80000000, 1'b0, 1'b0}, {32'h00000001, 1'b0, 1'b0},
        {32'hffffffff, 1'b0, 1'b0}, {32'h00000000, 1'b1, 1'b0},
        {32'haaaaaaaa, 1'b0, 1'b0}, {32'h55555555, 1'b0, 1'b0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [31:0] i_message_word;
    logic        i_final_word;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [31:0] o_digest_word;
    logic [2:0]  o_digest_index;
    logic        o_digest_last;

    // Predictor state: chaining value, message ring and word position
    logic [31:0]  chain_h [8];
    logic [31:0]  msg_ring [16];
    logic [3:0]   chunk_pos;

    t_digest_beat digest_due [$];
    int           words_sent;
    int           errors;
    int           stall_cycles;

    // No idling on either side through this stretch of words
    wire steady = (words_sent >= 120) && (words_sent < 170);

    sha256_block_hash_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_message_word (i_message_word),
        .i_final_word   (i_final_word),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_digest_word  (o_digest_word),
        .o_digest_index (o_digest_index),
        .o_digest_last  (o_digest_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        ror32 = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] sum0(input logic [31:0] x);
        sum0 = ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
    endfunction

    function automatic logic [31:0] sum1(input logic [31:0] x);
        sum1 = ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
    endfunction

    function automatic logic [31:0] mix0(input logic [31:0] x);
        mix0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] mix1(input logic [31:0] x);
        mix1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
    endfunction

    // Run 64 rounds over the ring and fold the result into the chaining value
    task automatic compress_chunk();
        logic [31:0] v [8];
        logic [31:0] w;
        logic [31:0] t1;
        logic [31:0] t2;
        for (int i = 0; i < 8; i++) v[i] = chain_h[i];
        for (int r = 0; r < 64; r++) begin
            if (r < 16) begin
                w = msg_ring[r];
            end else begin
                w = mix1(msg_ring[(r - 2) % 16]) + msg_ring[(r - 7) % 16]
                  + mix0(msg_ring[(r - 15) % 16]) + msg_ring[r % 16];
                msg_ring[r % 16] = w;
            end
            t1 = v[7] + sum1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[r] + w;
            t2 = sum0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain_h[i] = chain_h[i] + v[i];
    endtask

    // Take one accepted word; queue eight digest beats when a final block closes
    task automatic absorb_word(input logic [31:0] w, input logic fin, input logic known);
        t_digest_beat beat;
        logic [3:0]   slot;
        slot = chunk_pos;
        msg_ring[slot] = w;
        chunk_pos = chunk_pos + 4'd1;
        if (slot == 4'd15) begin
            compress_chunk();
            if (fin) begin
                for (int i = 0; i < 8; i++) begin
                    beat.word = known ? AbcDigest[i] : chain_h[i];
                    beat.idx  = 3'(i);
                    beat.last = (i == 7);
                    digest_due.push_back(beat);
                end
                for (int i = 0; i < 8; i++) chain_h[i] = StartH[i];
            end
        end
    endtask

    // Present one word, hold it until taken, then step the predictor
    task automatic send_word(input logic [31:0] w, input logic fin, input logic known);
        while (!steady && $urandom_range(99) < 26) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_message_word <= w;
        i_final_word   <= fin;
        do @(posedge i_clk); while (!o_in_ready);
        absorb_word(w, fin, known);
        words_sent++;
        @(negedge i_clk);
    endtask

    // Favour walking bits and solid words now and then
    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0: pick_word = 32'h00000000;
            1: pick_word = 32'hffffffff;
            2: pick_word = 32'h1 << $urandom_range(31);
            3: pick_word = ~(32'h1 << $urandom_range(31));
            default: pick_word = $urandom;
        endcase
    endfunction

    // Throttle the digest side
    always @(negedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(99) >= 26);
    end

    // Compare each digest beat against the oldest expectation
    always @(posedge i_clk) begin : check_digest
        t_digest_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (digest_due.size() == 0) begin
                $display("%0t: unexpected digest beat word %h index %0d last %0b",
                         $time, o_digest_word, o_digest_index, o_digest_last);
                errors++;
            end else begin
                want = digest_due.pop_front();
                if (o_digest_word !== want.word) begin
                    $display("%0t: digest_word expected %h actual %h",
                             $time, want.word, o_digest_word);
                    errors++;
                end
                if (o_digest_index !== want.idx) begin
                    $display("%0t: digest_index expected %0d actual %0d",
                             $time, want.idx, o_digest_index);
                    errors++;
                end
                if (o_digest_last !== want.last) begin
                    $display("%0t: digest_last expected %0b actual %0b",
                             $time, want.last, o_digest_last);
                    errors++;
                end
            end
        end
    end

    // Abort when neither channel moves a beat for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= StallLimit) begin
            $display("%0t: no beat moved for %0d cycles", $time, StallLimit);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : run
        int extra;
        int len;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_message_word = 32'h0;
        i_final_word   = 1'b0;
        i_out_ready    = 1'b0;
        words_sent     = 0;
        errors         = 0;
        stall_cycles   = 0;
        chunk_pos      = 4'd0;
        for (int i = 0; i < 8; i++) chain_h[i] = StartH[i];
        for (int i = 0; i < 16; i++) msg_ring[i] = 32'h0;

        // Hold reset, then release it
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Walk the directed table
        for (int n = 0; n < DirRows; n++) begin
            send_word(StimRows[n].word, StimRows[n].fin, StimRows[n].known);
        end

        // Random messages: finish the open block, sometimes add one or two more;
        // stray final marks fall on inner words now and then
        while (words_sent < DirRows + RandItems) begin
            extra = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
            len   = 16 - int'(chunk_pos) + 16 * extra;
            for (int k = 0; k < len; k++) begin
                send_word(pick_word(), (k == len - 1) || ($urandom_range(19) == 0), 1'b0);
            end
        end
        i_in_valid <= 1'b0;

        // Drain outstanding digest beats, then watch for strays
        while (digest_due.size() != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
